// ----- sv/bcrd_pkg.sv -----
`default_nettype none

package bcrd_pkg;

    localparam int unsigned MIN_STRONG_BYTES = 3;
    localparam int unsigned MAX_STRONG_BYTES = 16;
    localparam int unsigned MIN_SUM_BYTES    = 1;
    localparam int unsigned MAX_SUM_BYTES    = 4;
    localparam int unsigned MIN_SEQ_MATCHES  = 1;
    localparam int unsigned MAX_SEQ_MATCHES  = 2;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 48;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FILE_SIZE   = 3'd0,
        REG_BLOCK_SIZE  = 3'd1,
        REG_SEQ_MATCHES = 3'd2,
        REG_RSUM_LEN    = 3'd3,
        REG_STRONG_LEN  = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_BLOCK = 2'd1,
        ST_BAD_HASH  = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_flag;
    } in_beat_t;

    typedef struct packed {
        status_t     status;
        logic [47:0] block_index;
        logic [47:0] block_offset;
        logic [30:0] block_length;
        logic [31:0] rolling_sum;
        logic [63:0] strong_high;
        logic [63:0] strong_low;
        logic        final_block;
    } out_beat_t;

    typedef struct packed {
        logic [47:0] file_size;
        logic [30:0] block_size;
        logic [7:0]  seq_matches;
        logic [7:0]  rsum_len;
        logic [7:0]  strong_len;
    } cfg_t;

    // Bit position of a one-hot value; an OR of the positions of all set bits.
    function automatic logic [4:0] onehot_log2(input logic [30:0] v);
        logic [4:0] r;
        r = '0;
        for (int i = 0; i < 31; i++) begin
            if (v[i]) begin
                r = r | 5'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/bcrd_cfg_regs.sv -----
`default_nettype none

module bcrd_cfg_regs (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [bcrd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [bcrd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output bcrd_pkg::cfg_t                           cfg
);
    import bcrd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_FILE_SIZE:   cfg_reg.file_size   <= cfg_wdata[47:0];
                REG_BLOCK_SIZE:  cfg_reg.block_size  <= cfg_wdata[30:0];
                REG_SEQ_MATCHES: cfg_reg.seq_matches <= cfg_wdata[7:0];
                REG_RSUM_LEN:    cfg_reg.rsum_len    <= cfg_wdata[7:0];
                REG_STRONG_LEN:  cfg_reg.strong_len  <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- sv/bcrd_core.sv -----
`default_nettype none

module bcrd_core #(
    parameter int OFFSET_BITS = 48
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                beat_en,
    input  wire bcrd_pkg::in_beat_t  beat,
    input  wire bcrd_pkg::cfg_t      cfg,
    output logic                     res_valid,
    output bcrd_pkg::out_beat_t      res
);
    import bcrd_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_SUM    = 4'b0010,
        PH_STRONG = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    phase_t                 phase_reg, phase_next, phase_cur;
    logic [4:0]             pos_reg, pos_next, pos_base, pos_inc;
    logic [47:0]            cur_block_reg, cur_block_next;
    logic [OFFSET_BITS-1:0] cur_off_reg, cur_off_next;
    logic [47:0]            total_reg, total_next;
    logic [31:0]            sum_reg, sum_next, sum_base;
    logic [63:0]            hi_reg, hi_next, hi_base;
    logic [63:0]            lo_reg, lo_next, lo_base;
    logic [7:0]             lat_rsum_reg, lat_rsum_next;
    logic [7:0]             lat_strong_reg, lat_strong_next;
    logic [30:0]            lat_block_reg, lat_block_next;
    logic [30:0]            last_len_reg, last_len_next;

    // Start-byte checks and per-run constants, from the live configuration.
    logic [30:0] blk_m1;
    logic        blk_pow2;
    logic        bad_hash;
    logic [48:0] round_up;
    logic [48:0] total_shift;
    logic [30:0] rem;
    logic [30:0] last_len_calc;
    logic [7:0]  rsum_use;

    assign blk_m1   = cfg.block_size - 31'd1;
    assign blk_pow2 = (cfg.block_size != '0) && ((cfg.block_size & blk_m1) == '0);
    assign bad_hash = (cfg.strong_len < 8'(MIN_STRONG_BYTES))
                   || (cfg.strong_len > 8'(MAX_STRONG_BYTES))
                   || (cfg.rsum_len < 8'(MIN_SUM_BYTES))
                   || (cfg.rsum_len > 8'(MAX_SUM_BYTES))
                   || (cfg.seq_matches < 8'(MIN_SEQ_MATCHES))
                   || (cfg.seq_matches > 8'(MAX_SEQ_MATCHES));
    // Block size is a power of two, so the block count is a rounded-up shift.
    assign round_up      = {1'b0, cfg.file_size} + {18'd0, blk_m1};
    assign total_shift   = round_up >> onehot_log2(cfg.block_size);
    assign rem           = cfg.file_size[30:0] & blk_m1;
    assign last_len_calc = (rem == '0) ? cfg.block_size : rem;
    assign rsum_use      = beat.start_flag ? cfg.rsum_len : lat_rsum_reg;

    logic                     is_last;
    logic [30:0]              len;
    logic [OFFSET_BITS+47:0]  off_ext;

    assign is_last = ({1'b0, cur_block_reg} + 49'd1) >= {1'b0, total_reg};
    assign len     = is_last ? last_len_reg : lat_block_reg;
    assign off_ext = {48'd0, cur_off_reg};

    always_comb begin
        phase_next      = phase_reg;
        phase_cur       = phase_reg;
        pos_base        = pos_reg;
        sum_base        = sum_reg;
        hi_base         = hi_reg;
        lo_base         = lo_reg;
        pos_next        = pos_reg;
        pos_inc         = pos_reg + 5'd1;
        sum_next        = sum_reg;
        hi_next         = hi_reg;
        lo_next         = lo_reg;
        cur_block_next  = cur_block_reg;
        cur_off_next    = cur_off_reg;
        total_next      = total_reg;
        lat_rsum_next   = lat_rsum_reg;
        lat_strong_next = lat_strong_reg;
        lat_block_next  = lat_block_reg;
        last_len_next   = last_len_reg;
        res_valid       = 1'b0;
        res             = '0;

        if (beat_en) begin
            if (beat.start_flag) begin
                lat_rsum_next   = cfg.rsum_len;
                lat_strong_next = cfg.strong_len;
                lat_block_next  = cfg.block_size;
                last_len_next   = last_len_calc;
                cur_block_next  = '0;
                cur_off_next    = '0;
                total_next      = '0;
                pos_base        = '0;
                sum_base        = '0;
                hi_base         = '0;
                lo_base         = '0;
                if (!blk_pow2) begin
                    res_valid  = 1'b1;
                    res.status = ST_BAD_BLOCK;
                    phase_cur  = PH_IDLE;
                end else if (cfg.file_size == '0) begin
                    phase_cur = PH_DONE;
                end else if (bad_hash) begin
                    res_valid  = 1'b1;
                    res.status = ST_BAD_HASH;
                    phase_cur  = PH_IDLE;
                end else begin
                    total_next = total_shift[47:0];
                    phase_cur  = PH_SUM;
                end
            end

            phase_next = phase_cur;
            pos_next   = pos_base;
            sum_next   = sum_base;
            hi_next    = hi_base;
            lo_next    = lo_base;
            pos_inc    = pos_base + 5'd1;

            case (phase_cur)
                PH_SUM: begin
                    sum_next = {sum_base[23:0], beat.data_byte};
                    if ({3'd0, pos_inc} >= rsum_use) begin
                        phase_next = PH_STRONG;
                        pos_next   = '0;
                    end else begin
                        pos_next = pos_inc;
                    end
                end
                PH_STRONG: begin
                    // Byte k of the strong checksum lands in byte lane k, MSB first.
                    for (int i = 0; i < 8; i++) begin
                        if (pos_base[2:0] == 3'(i) && !pos_base[4]) begin
                            if (!pos_base[3]) begin
                                hi_next[63-8*i -: 8] = hi_base[63-8*i -: 8] | beat.data_byte;
                            end else begin
                                lo_next[63-8*i -: 8] = lo_base[63-8*i -: 8] | beat.data_byte;
                            end
                        end
                    end
                    if ({3'd0, pos_inc} < lat_strong_reg) begin
                        pos_next = pos_inc;
                    end else begin
                        res_valid        = 1'b1;
                        res.status       = ST_OK;
                        res.block_index  = cur_block_reg;
                        res.block_offset = off_ext[47:0];
                        res.block_length = len;
                        res.rolling_sum  = sum_base;
                        res.strong_high  = hi_next;
                        res.strong_low   = lo_next;
                        res.final_block  = is_last;
                        cur_off_next     = cur_off_reg + OFFSET_BITS'(len);
                        cur_block_next   = cur_block_reg + 48'd1;
                        pos_next         = '0;
                        sum_next         = '0;
                        hi_next          = '0;
                        lo_next          = '0;
                        phase_next       = is_last ? PH_DONE : PH_SUM;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            pos_reg        <= '0;
            cur_block_reg  <= '0;
            cur_off_reg    <= '0;
            total_reg      <= '0;
            sum_reg        <= '0;
            hi_reg         <= '0;
            lo_reg         <= '0;
            lat_rsum_reg   <= '0;
            lat_strong_reg <= '0;
            lat_block_reg  <= '0;
            last_len_reg   <= '0;
        end else begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            cur_block_reg  <= cur_block_next;
            cur_off_reg    <= cur_off_next;
            total_reg      <= total_next;
            sum_reg        <= sum_next;
            hi_reg         <= hi_next;
            lo_reg         <= lo_next;
            lat_rsum_reg   <= lat_rsum_next;
            lat_strong_reg <= lat_strong_next;
            lat_block_reg  <= lat_block_next;
            last_len_reg   <= last_len_next;
        end
    end

    // A start byte can only report a configuration error, never a record.
    a_start_no_record: assert property (@(posedge aclk) disable iff (!aresetn)
        beat_en && beat.start_flag && res_valid |-> res.status != ST_OK)
        else $error("record emitted on a start beat");

    a_error_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.status != ST_OK |->
            res.block_index == '0 && res.strong_high == '0 && res.final_block == 1'b0)
        else $error("error result carries record fields");

    a_record_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.status == ST_OK |-> res.block_length != '0)
        else $error("record with zero block length");

    a_result_needs_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> beat_en)
        else $error("result without an accepted beat");

endmodule

`default_nettype wire

// ----- sv/bcrd_skid.sv -----
`default_nettype none

module bcrd_skid (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire bcrd_pkg::out_beat_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output bcrd_pkg::out_beat_t       out_data
);
    import bcrd_pkg::*;

    logic      main_valid_reg;
    logic      skid_valid_reg;
    out_beat_t main_data_reg;
    out_beat_t skid_data_reg;

    // Ready is registered: a second slot catches the beat that arrives while
    // the output is stalled.
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !main_valid_reg) begin
            main_valid_reg <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !main_valid_reg) begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid && !skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid slot full while output slot empty");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid |-> in_ready)
        else $error("result offered while both slots are full");

    a_skid_stays_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !skid_valid_reg && !in_valid |=> !skid_valid_reg)
        else $error("skid slot filled without an incoming result");

endmodule

`default_nettype wire

// ----- sv/block_checksum_record_deframer.sv -----
// Record-area deframer for a block-checksum control file.
// Input: one byte per beat on s_valid/s_ready; s_data.start_flag marks the
// first byte of the area and samples file size, block size and hash lengths
// written earlier through cfg_wr_en/cfg_addr/cfg_wdata.
// Output: one beat on m_valid/m_ready per completed record (index, offset,
// length, rolling sum, strong checksum, final flag), or one error beat when
// a start byte finds a bad block size or bad hash lengths.
// Every byte is processed in the cycle it is accepted; a result is registered
// into the output slot, or into the skid slot while the output is stalled,
// before it shows on m_valid. Throughput is one byte per cycle while s_ready
// is high, set by the single register-to-register pass of the record logic.
// When the receiver stalls, a two-entry output buffer keeps taking bytes;
// s_ready falls only once two results wait, and rises in the cycle after
// m_ready returns.
// Reset (aresetn low, synchronous) clears configuration to zero, drops any
// pending results and leaves the block idle until the next start byte.
`default_nettype none

module block_checksum_record_deframer #(
    parameter int OFFSET_BITS = 48
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire bcrd_pkg::in_beat_t                 s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output bcrd_pkg::out_beat_t                     m_data,
    input  wire logic                               cfg_wr_en,
    input  wire logic [bcrd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [bcrd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import bcrd_pkg::*;

    cfg_t      cfg;
    logic      beat_en;
    logic      res_valid;
    out_beat_t res;

    assign beat_en = s_valid && s_ready;

    bcrd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bcrd_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat_en   (beat_en),
        .beat      (s_data),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    bcrd_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (s_ready),
        .in_data   (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import bcrd_pkg::*;

    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 16;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1800;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SUM,
        PH_STRONG,
        PH_DONE
    } parse_phase_t;

    typedef struct {
        bit          is_cfg;
        cfg_reg_t    reg_idx;
        logic [47:0] value;
        in_beat_t    beat;
        bit          typed;
        status_t     typed_status;
    } dir_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_beat_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_beat_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Record parser shadow state.
    cfg_t               cfg_shadow   = '0;
    cfg_t               cfg_live     = '0;
    parse_phase_t       phase_q      = PH_IDLE;
    logic [4:0]         byte_pos     = '0;
    logic [47:0]        cur_block    = '0;
    logic [47:0]        cur_offset   = '0;
    logic [47:0]        blocks_total = '0;
    logic [31:0]        sum_acc      = '0;
    logic [1:0][63:0]   strong_acc   = '0;

    out_beat_t expected_records[$];
    dir_row_t  dir_rows[$];
    int        fail_count  = 0;
    int        cycle_count = 0;
    int        items_used  = 0;
    int        tx_idle_pct = 30;
    int        rx_idle_pct = 71;

    block_checksum_record_deframer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("block_checksum_record_deframer regression: fail");
            $finish;
        end
    end

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_records.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual %h", $time, m_data);
                fail_count++;
            end else begin
                want = expected_records.pop_front();
                check_field("status", 64'(want.status), 64'(m_data.status));
                check_field("block_index", 64'(want.block_index), 64'(m_data.block_index));
                check_field("block_offset", 64'(want.block_offset), 64'(m_data.block_offset));
                check_field("block_length", 64'(want.block_length), 64'(m_data.block_length));
                check_field("rolling_sum", 64'(want.rolling_sum), 64'(m_data.rolling_sum));
                check_field("strong_high", want.strong_high, m_data.strong_high);
                check_field("strong_low", want.strong_low, m_data.strong_low);
                check_field("final_block", 64'(want.final_block), 64'(m_data.final_block));
            end
        end
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Advances the parser by one byte and returns the record or error result it produces, if any.
    task automatic parse_byte(input in_beat_t b, output bit emitted, output out_beat_t res);
        logic [63:0] bsz;
        logic [63:0] len;
        bit          last;
        int          k;
        emitted = 0;
        res     = '0;
        if (b.start_flag || phase_q == PH_SUM || phase_q == PH_STRONG) begin
            items_used++;
        end
        if (b.start_flag) begin
            cfg_live     = cfg_shadow;
            cur_block    = '0;
            cur_offset   = '0;
            blocks_total = '0;
            byte_pos     = '0;
            sum_acc      = '0;
            strong_acc   = '0;
            bsz = 64'(cfg_live.block_size);
            if (bsz == 0 || (bsz & (bsz - 1)) != 0) begin
                res.status = ST_BAD_BLOCK;
                emitted    = 1;
                phase_q    = PH_IDLE;
                return;
            end
            // An empty file skips the hash length check entirely.
            if (cfg_live.file_size == 0) begin
                phase_q = PH_DONE;
                return;
            end
            if (cfg_live.strong_len < MIN_STRONG_BYTES || cfg_live.strong_len > MAX_STRONG_BYTES ||
                cfg_live.rsum_len < MIN_SUM_BYTES || cfg_live.rsum_len > MAX_SUM_BYTES ||
                cfg_shadow.seq_matches < MIN_SEQ_MATCHES ||
                cfg_shadow.seq_matches > MAX_SEQ_MATCHES) begin
                res.status = ST_BAD_HASH;
                emitted    = 1;
                phase_q    = PH_IDLE;
                return;
            end
            blocks_total = 48'((64'(cfg_live.file_size) + bsz - 1) / bsz);
            phase_q      = PH_SUM;
        end
        bsz = 64'(cfg_live.block_size);
        if (phase_q == PH_SUM) begin
            sum_acc  = {sum_acc[23:0], b.data_byte};
            byte_pos = byte_pos + 1;
            if (byte_pos >= cfg_live.rsum_len) begin
                phase_q  = PH_STRONG;
                byte_pos = '0;
            end
            return;
        end
        if (phase_q == PH_STRONG) begin
            k = byte_pos;
            if (k < 16) begin
                strong_acc[k / 8] = strong_acc[k / 8] | (64'(b.data_byte) << (56 - 8 * (k % 8)));
            end
            byte_pos = byte_pos + 1;
            if (byte_pos < cfg_live.strong_len) begin
                return;
            end
            last = (64'(cur_block) + 64'd1) >= 64'(blocks_total);
            len  = bsz;
            if (last) begin
                len = 64'(cfg_live.file_size) & (bsz - 1);
                if (len == 0) begin
                    len = bsz;
                end
            end
            res.status       = ST_OK;
            res.block_index  = cur_block;
            res.block_offset = cur_offset;
            res.block_length = len[30:0];
            res.rolling_sum  = sum_acc;
            res.strong_high  = strong_acc[0];
            res.strong_low   = strong_acc[1];
            res.final_block  = last;
            emitted          = 1;
            cur_offset = cur_offset + len[47:0];
            cur_block  = cur_block + 1;
            byte_pos   = '0;
            sum_acc    = '0;
            strong_acc = '0;
            phase_q    = last ? PH_DONE : PH_SUM;
        end
    endtask

    // Registers change only once all results are out and the pipeline has drained.
    task automatic write_reg(input cfg_reg_t idx, input logic [47:0] value);
        s_valid <= 1'b0;
        while (expected_records.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_FILE_SIZE:   cfg_shadow.file_size   = value;
            REG_BLOCK_SIZE:  cfg_shadow.block_size  = value[30:0];
            REG_SEQ_MATCHES: cfg_shadow.seq_matches = value[7:0];
            REG_RSUM_LEN:    cfg_shadow.rsum_len    = value[7:0];
            REG_STRONG_LEN:  cfg_shadow.strong_len  = value[7:0];
            default: ;
        endcase
    endtask

    task automatic send_beat(input in_beat_t b, input bit typed, input status_t typed_status);
        bit        emitted;
        out_beat_t res;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        parse_byte(b, emitted, res);
        if (typed) begin
            res        = '0;
            res.status = typed_status;
            emitted    = 1;
        end
        if (emitted) begin
            expected_records.insert(expected_records.size(), res);
        end
    endtask

    function automatic dir_row_t blank_row();
        dir_row_t r;
        r.is_cfg       = 1'b0;
        r.reg_idx      = REG_FILE_SIZE;
        r.value        = '0;
        r.beat         = '0;
        r.typed        = 1'b0;
        r.typed_status = ST_OK;
        return r;
    endfunction

    task automatic row_cfg(input cfg_reg_t idx, input logic [47:0] value);
        dir_row_t r;
        r         = blank_row();
        r.is_cfg  = 1;
        r.reg_idx = idx;
        r.value   = value;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic row_beat(input logic [7:0] data, input bit start);
        dir_row_t r;
        r                 = blank_row();
        r.beat.data_byte  = data;
        r.beat.start_flag = start;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic row_error(input status_t st);
        dir_row_t r;
        r                 = blank_row();
        r.beat.data_byte  = 8'($urandom_range(0, 255));
        r.beat.start_flag = 1'b1;
        r.typed           = 1;
        r.typed_status    = st;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    // One configuration followed by one record area, mostly well formed.
    task automatic run_segment();
        int          choice;
        int          nblk;
        int          rs;
        int          sl;
        int          sq;
        int          body;
        int          noise;
        logic [63:0] bs;
        logic [63:0] fs;
        logic [47:0] junk;
        bit          bad;
        in_beat_t    beats[$];
        in_beat_t    b;
        choice = $urandom_range(0, 99);
        bs     = 64'd1 << $urandom_range(0, 30);
        rs     = $urandom_range(MIN_SUM_BYTES, MAX_SUM_BYTES);
        sl     = $urandom_range(MIN_STRONG_BYTES, MAX_STRONG_BYTES);
        sq     = $urandom_range(MIN_SEQ_MATCHES, MAX_SEQ_MATCHES);
        nblk   = $urandom_range(1, 6);
        fs     = 64'(nblk - 1) * bs + 64'($urandom_range(1, 32'(bs)));
        bad    = 0;
        if (choice < 8) begin
            fs   = 64'(48'({$urandom, $urandom}));
            nblk = $urandom_range(1, 4);
        end else if (choice < 12) begin
            fs  = 0;
            bad = 1;
        end else if (choice < 17) begin
            bs  = $urandom_range(0, 1) ? 64'd0 : 64'(31'($urandom | 3));
            bad = 1;
        end else if (choice < 25) begin
            case ($urandom_range(0, 2))
                0: rs = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_SUM_BYTES + 1, 255);
                1: sl = $urandom_range(0, 1) ? $urandom_range(0, MIN_STRONG_BYTES - 1)
                                             : $urandom_range(MAX_STRONG_BYTES + 1, 255);
                default: sq = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_SEQ_MATCHES + 1, 255);
            endcase
            bad = 1;
        end
        junk = 48'({$urandom, $urandom});
        write_reg(REG_FILE_SIZE, fs[47:0]);
        write_reg(REG_BLOCK_SIZE, {junk[47:31], bs[30:0]});
        junk = 48'({$urandom, $urandom});
        write_reg(REG_SEQ_MATCHES, {junk[47:8], 8'(sq)});
        write_reg(REG_RSUM_LEN, {junk[39:0], 8'(rs)});
        write_reg(REG_STRONG_LEN, {junk[31:0], junk[47:40], 8'(sl)});

        if ($urandom_range(0, 9) == 0) begin
            noise = $urandom_range(1, 3);
            repeat (noise) begin
                b.data_byte  = 8'($urandom);
                b.start_flag = 1'b0;
                beats.insert(beats.size(), b);
            end
        end
        b.data_byte  = 8'($urandom);
        b.start_flag = 1'b1;
        beats.insert(beats.size(), b);
        body = bad ? $urandom_range(0, 4) : nblk * (rs + sl) - 1 + $urandom_range(0, 3);
        repeat (body) begin
            b.data_byte  = 8'($urandom);
            b.start_flag = 1'b0;
            beats.insert(beats.size(), b);
        end
        // Now and then a second start byte cuts a record short.
        if (body > 0 && $urandom_range(0, 9) == 0) begin
            beats[$urandom_range(1, beats.size() - 1)].start_flag = 1'b1;
        end
        foreach (beats[i]) begin
            send_beat(beats[i], 1'b0, ST_OK);
        end
    endtask

    initial begin
        row_error(ST_BAD_BLOCK);
        row_cfg(REG_BLOCK_SIZE, 48'd3);
        row_error(ST_BAD_BLOCK);
        // Empty file with all hash lengths still zero: nothing comes out.
        row_cfg(REG_BLOCK_SIZE, 48'h0000_4000_0000);
        row_beat(8'hFF, 1'b1);
        row_beat(8'h00, 1'b0);
        row_cfg(REG_FILE_SIZE, 48'hFFFF_FFFF_FFFF);
        row_cfg(REG_RSUM_LEN, 48'd4);
        row_cfg(REG_STRONG_LEN, 48'd16);
        row_error(ST_BAD_HASH);
        row_cfg(REG_SEQ_MATCHES, 48'd3);
        row_error(ST_BAD_HASH);
        row_cfg(REG_SEQ_MATCHES, 48'd2);
        row_cfg(REG_RSUM_LEN, 48'd5);
        row_error(ST_BAD_HASH);
        row_cfg(REG_RSUM_LEN, 48'd1);
        row_cfg(REG_STRONG_LEN, 48'd17);
        row_error(ST_BAD_HASH);
        row_cfg(REG_STRONG_LEN, 48'd2);
        row_error(ST_BAD_HASH);
        // Ten bytes in blocks of four: lengths 4, 4 and a short last block of 2.
        row_cfg(REG_FILE_SIZE, 48'd10);
        row_cfg(REG_BLOCK_SIZE, 48'd4);
        row_cfg(REG_SEQ_MATCHES, 48'd1);
        row_cfg(REG_STRONG_LEN, 48'd3);
        row_beat(8'h5A, 1'b1);
        row_beat(8'hC3, 1'b0);
        row_beat(8'hFF, 1'b1);
        row_beat(8'h00, 1'b0);
        row_beat(8'h80, 1'b0);
        row_beat(8'h01, 1'b0);
        row_beat(8'h00, 1'b0);
        row_beat(8'hFF, 1'b0);
        row_beat(8'hFF, 1'b0);
        row_beat(8'hFF, 1'b0);
        row_beat(8'h12, 1'b0);
        row_beat(8'h34, 1'b0);
        row_beat(8'h56, 1'b0);
        row_beat(8'h78, 1'b0);
        row_beat(8'h9A, 1'b0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
            end else begin
                send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].typed_status);
            end
        end

        items_used = 0;
        while (items_used < RANDOM_ITEMS) begin
            if (items_used < RANDOM_ITEMS / 3) begin
                tx_idle_pct = 30;
                rx_idle_pct = 71;
            end else if (items_used < 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 71;
                rx_idle_pct = 30;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            run_segment();
        end

        s_valid <= 1'b0;
        while (expected_records.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_records.size() == 0) begin
            $display("block_checksum_record_deframer regression: pass");
        end else begin
            $display("block_checksum_record_deframer regression: fail");
        end
        $finish;
    end

endmodule

// ----- block_checksum_record_deframer.f -----
sv/bcrd_pkg.sv
sv/bcrd_cfg_regs.sv
sv/bcrd_core.sv
sv/bcrd_skid.sv
sv/block_checksum_record_deframer.sv
bench/tb_top.sv
